// ----- hdl/spq_pkg.sv -----
// Package for the sorted priority queue with lookup: sizes, codes, name helper.
// No dependencies; used by sorted_priority_queue_with_lookup_core.
package spq_pkg;

  localparam int Depth = 32;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int EntW  = 16 + 64 + 64 + 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_LIST   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_MATCH     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_LIST      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_QUERY,
    S_LIST,
    S_DONE
  } state_t;

  // Zero every byte after the first zero byte of a 20-byte name.
  function automatic logic [159:0] norm_name(input logic [159:0] n);
    logic [159:0] r;
    logic         ended;
    r     = n;
    ended = 1'b0;
    for (int k = 0; k < 20; k++) begin
      if (ended) r[159 - 8*k -: 8] = 8'h00;
      else if (n[159 - 8*k -: 8] == 8'h00) ended = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/sorted_priority_queue_with_lookup_core.sv -----
// Sorted priority queue with name lookup: top level, built on one slot memory; uses spq_pkg.
// Busy holds while an insert, query or list runs, also for the single reply state of an insert
// into a full queue or a list of an empty queue.
// The last result strobes in the same cycle that busy falls, when a new request can already
// be accepted. The receiver cannot stall results.
// Synchronous active-high reset empties the queue; slot memory is not cleared.
module sorted_priority_queue_with_lookup_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [15:0] priority_req,
  input  logic [63:0] name_hi,
  input  logic [63:0] name_mid,
  input  logic [31:0] name_lo,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [5:0]  position,
  output logic [15:0] entry_priority,
  output logic [63:0] entry_name_hi,
  output logic [63:0] entry_name_mid,
  output logic [31:0] entry_name_lo,
  output logic        last
);

  localparam int IW = spq_pkg::IdxW;
  localparam int CW = spq_pkg::CntW;
  localparam int EW = spq_pkg::EntW;

  // Slot memory: {priority, name}, one read and one write port.
  logic [EW-1:0] mem [spq_pkg::Depth];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  spq_pkg::state_t state, state_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx;       // slot whose read data arrives this cycle
  logic [1:0]     req;
  logic [15:0]    prio;
  logic [159:0]   name;
  logic [EW-1:0]  carry;     // entry to drop into the next slot during shift
  logic [CW-1:0]  ins_pos;
  logic           ins_pos_valid;

  // Hold one match back until the next match or the end of the scan settles its last flag.
  logic           held;
  logic [CW-1:0]  held_pos;
  logic [EW-1:0]  held_ent;

  // Next values of the result registers.
  logic           emit;
  logic [2:0]     status_next;
  logic [5:0]     position_next;
  logic [15:0]    entry_priority_next;
  logic [159:0]   entry_name_next;
  logic           last_next;

  wire [15:0]   rd_prio = rd_data[EW-1 -: 16];
  wire [159:0]  rd_name = rd_data[159:0];
  wire [CW-1:0] idx_inc = idx + CW'(1);
  wire          at_end  = (idx >= count);
  wire          hit     = (rd_name == name);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE:
        if (start) begin
          case (spq_pkg::req_t'(req_type))
            spq_pkg::REQ_INSERT: state_next = (count >= CW'(spq_pkg::Depth)) ?
                                   spq_pkg::S_DONE : spq_pkg::S_INS_SCAN;
            spq_pkg::REQ_QUERY:  state_next = spq_pkg::S_QUERY;
            spq_pkg::REQ_LIST:   state_next = (count == '0) ? spq_pkg::S_DONE
                                                           : spq_pkg::S_LIST;
            default:             state_next = spq_pkg::S_IDLE;
          endcase
        end
      spq_pkg::S_INS_SCAN:
        if (at_end) state_next = spq_pkg::S_DONE;
        else if (rd_prio > prio) state_next = spq_pkg::S_INS_SHIFT;
      spq_pkg::S_INS_SHIFT:
        if (at_end) state_next = spq_pkg::S_DONE;
      spq_pkg::S_QUERY:
        if (at_end) state_next = spq_pkg::S_IDLE;
      spq_pkg::S_LIST:
        if (idx_inc >= count) state_next = spq_pkg::S_IDLE;
      spq_pkg::S_DONE: state_next = spq_pkg::S_IDLE;
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  // Memory control: read slot 0 while idle, else the slot after idx, so data for idx
  // is always back. Writes go to idx, never to the slot being read.
  always_comb begin
    rd_addr = (state == spq_pkg::S_IDLE) ? '0 : idx_inc[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = carry;
    case (state)
      spq_pkg::S_INS_SCAN:
        if (at_end || rd_prio > prio) begin
          wr_en   = 1'b1;
          wr_data = {prio, name};
        end
      spq_pkg::S_INS_SHIFT: wr_en = 1'b1;
      default: ;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spq_pkg::S_IDLE;
      count         <= '0;
      idx           <= '0;
      held          <= 1'b0;
      ins_pos_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        spq_pkg::S_IDLE: begin
          idx  <= '0;
          held <= 1'b0;
          if (start) begin
            req  <= req_type;
            prio <= priority_req;
            name <= spq_pkg::norm_name({name_hi, name_mid, name_lo});
            // Insert succeeds unless the queue is full on entry.
            ins_pos_valid <= (count < CW'(spq_pkg::Depth));
          end
        end
        spq_pkg::S_INS_SCAN: begin
          if (at_end) begin
            // Append after every entry.
            ins_pos <= idx;
            count   <= count + CW'(1);
          end else if (rd_prio > prio) begin
            // Take this slot, carry the old entry forward.
            ins_pos <= idx;
            carry   <= rd_data;
            idx     <= idx_inc;
          end else begin
            idx <= idx_inc;
          end
        end
        spq_pkg::S_INS_SHIFT: begin
          if (at_end) begin
            count <= count + CW'(1);
          end else begin
            carry <= rd_data;
            idx   <= idx_inc;
          end
        end
        spq_pkg::S_QUERY: begin
          if (!at_end) begin
            if (hit) begin
              held     <= 1'b1;
              held_pos <= idx;
              held_ent <= rd_data;
            end
            idx <= idx_inc;
          end
        end
        spq_pkg::S_LIST: idx <= idx_inc;
        default: ;
      endcase
    end
  end

  // Result selection.
  always_comb begin
    emit                = 1'b0;
    status_next         = spq_pkg::ST_EMPTY;
    position_next       = '0;
    entry_priority_next = '0;
    entry_name_next     = '0;
    last_next           = 1'b1;
    case (state)
      spq_pkg::S_QUERY:
        if (!at_end && hit && held) begin
          // A later match exists: release the held one as not last.
          emit                = 1'b1;
          status_next         = spq_pkg::ST_MATCH;
          position_next       = 6'(held_pos);
          entry_priority_next = held_ent[EW-1 -: 16];
          entry_name_next     = held_ent[159:0];
          last_next           = 1'b0;
        end else if (at_end) begin
          emit = 1'b1;
          if (held) begin
            status_next         = spq_pkg::ST_MATCH;
            position_next       = 6'(held_pos);
            entry_priority_next = held_ent[EW-1 -: 16];
            entry_name_next     = held_ent[159:0];
          end else begin
            status_next = spq_pkg::ST_NOT_FOUND;
          end
        end
      spq_pkg::S_LIST: begin
        emit                = 1'b1;
        status_next         = spq_pkg::ST_LIST;
        position_next       = 6'(idx);
        entry_priority_next = rd_prio;
        entry_name_next     = rd_name;
        last_next           = (idx_inc >= count);
      end
      spq_pkg::S_DONE: begin
        // Insert reply, or the empty list reply with all fields zero.
        emit = 1'b1;
        if (spq_pkg::req_t'(req) == spq_pkg::REQ_INSERT) begin
          status_next         = ins_pos_valid ? spq_pkg::ST_INSERTED : spq_pkg::ST_FULL;
          position_next       = ins_pos_valid ? 6'(ins_pos) : 6'd0;
          entry_priority_next = prio;
          entry_name_next     = name;
        end
      end
      default: ;
    endcase
  end

  // Result registers: strobe for exactly one cycle per result.
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= emit;
    if (emit) begin
      status         <= status_next;
      position       <= position_next;
      entry_priority <= entry_priority_next;
      {entry_name_hi, entry_name_mid, entry_name_lo} <= entry_name_next;
      last           <= last_next;
    end
  end

  assign busy = (state != spq_pkg::S_IDLE);

endmodule

// ----- verif/sorted_priority_queue_with_lookup_core_tb.sv -----
// Self-checking testbench for sorted_priority_queue_with_lookup_core.
// Drives insert, query and list requests and checks every result against an in-bench queue model.
// Depends on spq_pkg and the core RTL.
module sorted_priority_queue_with_lookup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [15:0] priority_req;
  logic [63:0] name_hi;
  logic [63:0] name_mid;
  logic [31:0] name_lo;
  logic        strobe;
  logic [2:0]  status;
  logic [5:0]  position;
  logic [15:0] entry_priority;
  logic [63:0] entry_name_hi;
  logic [63:0] entry_name_mid;
  logic [31:0] entry_name_lo;
  logic        last;

  // One result as the block should emit it.
  typedef struct packed {
    spq_pkg::status_t st;
    logic [5:0]       pos;
    logic [15:0]      prio;
    logic [159:0]     name;
    logic             lst;
  } queue_result_t;

  queue_result_t pending_results[$];

  // Shadow copy of the queue contents.
  logic [15:0]  shadow_prio[spq_pkg::Depth];
  logic [159:0] shadow_name[spq_pkg::Depth];
  int           shadow_count;

  int mismatch_count;
  int result_count;
  int item_count;
  int cycle_count;

  sorted_priority_queue_with_lookup_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .priority_req(priority_req),
    .name_hi(name_hi), .name_mid(name_mid), .name_lo(name_lo),
    .strobe(strobe), .status(status), .position(position),
    .entry_priority(entry_priority), .entry_name_hi(entry_name_hi),
    .entry_name_mid(entry_name_mid), .entry_name_lo(entry_name_lo),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cut the name at its first zero byte.
  function automatic logic [159:0] trim_name(input logic [159:0] n);
    logic [159:0] r;
    logic         ended;
    r = n;
    ended = 1'b0;
    for (int k = 0; k < 20; k++) begin
      if (ended) r[159 - 8*k -: 8] = 8'h00;
      else if (r[159 - 8*k -: 8] == 8'h00) ended = 1'b1;
    end
    return r;
  endfunction

  // Apply one request to the shadow queue and queue up the results it causes.
  task automatic predict_queue_results(input spq_pkg::req_t rq, input logic [15:0] p,
                                       input logic [159:0] raw);
    logic [159:0] nm;
    int           slot;
    int           hits;
    nm = trim_name(raw);
    hits = 0;
    case (rq)
      spq_pkg::REQ_INSERT: begin
        if (shadow_count >= spq_pkg::Depth) begin
          pending_results.push_back('{spq_pkg::ST_FULL, 6'd0, p, nm, 1'b1});
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_prio[slot] <= p) slot++;
          for (int i = shadow_count; i > slot; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_name[i] = shadow_name[i-1];
          end
          shadow_prio[slot] = p;
          shadow_name[slot] = nm;
          shadow_count++;
          pending_results.push_back('{spq_pkg::ST_INSERTED, 6'(slot), p, nm, 1'b1});
        end
      end
      spq_pkg::REQ_QUERY: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_name[i] == nm) begin
            pending_results.push_back('{spq_pkg::ST_MATCH, 6'(i), shadow_prio[i],
                                        shadow_name[i], 1'b0});
            hits++;
          end
        end
        if (hits == 0)
          pending_results.push_back('{spq_pkg::ST_NOT_FOUND, 6'd0, 16'd0, 160'd0, 1'b1});
        else pending_results[$].lst = 1'b1;
      end
      spq_pkg::REQ_LIST: begin
        if (shadow_count == 0) begin
          pending_results.push_back('{spq_pkg::ST_EMPTY, 6'd0, 16'd0, 160'd0, 1'b1});
        end else begin
          for (int i = 0; i < shadow_count; i++)
            pending_results.push_back('{spq_pkg::ST_LIST, 6'(i), shadow_prio[i],
                                        shadow_name[i], 1'(i == shadow_count - 1)});
        end
      end
      default: ;  // code three is ignored
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Sometimes hold start low for a random gap, then present one item and wait until busy is low.
  task automatic send_item(input spq_pkg::req_t rq, input logic [15:0] p,
                           input logic [159:0] nm);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start    <= 1'b0;
      req_type <= spq_pkg::REQ_NONE;
      repeat (gap) @(posedge clk);
    end
    req_type     <= rq;
    priority_req <= p;
    name_hi      <= nm[159:96];
    name_mid     <= nm[95:32];
    name_lo      <= nm[31:0];
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_results(rq, p, nm);
    item_count++;
  endtask

  // Check every strobed result against the oldest expectation.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && strobe) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("status %0d want %0d", status, want.st));
        if (position !== want.pos)
          report_mismatch($sformatf("position %0d want %0d", position, want.pos));
        if (entry_priority !== want.prio)
          report_mismatch($sformatf("priority %h want %h", entry_priority, want.prio));
        if ({entry_name_hi, entry_name_mid, entry_name_lo} !== want.name)
          report_mismatch($sformatf("name %h want %h",
                          {entry_name_hi, entry_name_mid, entry_name_lo}, want.name));
        if (last !== want.lst)
          report_mismatch($sformatf("last %b want %b", last, want.lst));
      end
    end
  end

  // Drop the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Random printable name of 1..20 characters, rest zero, optional junk after the end.
  function automatic logic [159:0] make_name(input int len, input bit junk);
    logic [159:0] n;
    n = '0;
    for (int k = 0; k < 20; k++) begin
      if (k < len) n[159 - 8*k -: 8] = 8'($urandom_range(8'h41, 8'h44));
      else if (junk && k > len) n[159 - 8*k -: 8] = 8'($urandom);
    end
    return n;
  endfunction

  function automatic logic [159:0] random_bits_name();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Empty queue: list and query give the empty and not-found statuses; code three is silent.
  task automatic test_empty_queue();
    send_item(spq_pkg::REQ_LIST, 16'd0, '0);
    send_item(spq_pkg::REQ_QUERY, 16'd0, make_name(3, 0));
    send_item(spq_pkg::REQ_NONE, 16'hFFFF, random_bits_name());
  endtask

  // Extremes of priority, ties, full-length and junk-padded names, matches.
  task automatic test_directed_entries();
    logic [159:0] nm;
    nm = make_name(2, 0);
    send_item(spq_pkg::REQ_INSERT, 16'hFFFF, {160{1'b1}});
    send_item(spq_pkg::REQ_INSERT, 16'd0, nm);
    send_item(spq_pkg::REQ_INSERT, 16'h8000, make_name(20, 0));
    send_item(spq_pkg::REQ_INSERT, 16'h8000, nm | 160'h00FF00FF);  // junk after terminator
    send_item(spq_pkg::REQ_INSERT, 16'd0, '0);                     // empty name
    send_item(spq_pkg::REQ_QUERY, 16'd0, nm);
    send_item(spq_pkg::REQ_QUERY, 16'd0, {160{1'b1}});
    send_item(spq_pkg::REQ_QUERY, 16'd0, '0);
    send_item(spq_pkg::REQ_QUERY, 16'd0, make_name(19, 0) | 160'h1);
    send_item(spq_pkg::REQ_LIST, 16'd0, '0);
  endtask

  // Fill past capacity so inserts drop, then list and query the full queue.
  task automatic test_full_queue();
    while (shadow_count < spq_pkg::Depth)
      send_item(spq_pkg::REQ_INSERT, 16'($urandom_range(0, 15)),
                make_name($urandom_range(1, 2), 0));
    send_item(spq_pkg::REQ_INSERT, 16'd5, make_name(1, 1));
    send_item(spq_pkg::REQ_INSERT, 16'($urandom), random_bits_name());
    send_item(spq_pkg::REQ_LIST, 16'd0, '0);
    send_item(spq_pkg::REQ_QUERY, 16'd0, make_name(1, 0));
  endtask

  // Random requests on names drawn from a small alphabet so queries hit often.
  task automatic test_random_requests(input int n);
    int            pick;
    spq_pkg::req_t rq;
    logic [159:0]  nm;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) rq = spq_pkg::REQ_INSERT;
      else if (pick < 15) rq = spq_pkg::REQ_QUERY;
      else if (pick < 18) rq = spq_pkg::REQ_LIST;
      else rq = spq_pkg::REQ_NONE;
      if ($urandom_range(0, 7) == 0) nm = random_bits_name();
      else nm = make_name($urandom_range(1, 3), $urandom_range(0, 1));
      send_item(rq, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7)), nm);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = spq_pkg::REQ_NONE;
    priority_req = '0;
    name_hi = '0;
    name_mid = '0;
    name_lo = '0;
    shadow_count = 0;
    mismatch_count = 0;
    result_count = 0;
    item_count = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_directed_entries();
    test_full_queue();
    test_random_requests(136);
    start    <= 1'b0;
    req_type <= spq_pkg::REQ_NONE;

    // Drain: wait for outstanding results, then let the bench idle before the final report.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("expected results never arrived");

    $display("Sent %0d items, checked %0d results, %0d mismatches.",
             item_count, result_count, mismatch_count);
    $display("Covered inserts incl. ties and full drops, queries, lists, ignored codes.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
